/* src/spmq_pkg.sv */
// Shared types and constants for the strict-priority multi-queue.
package spmq_pkg;

  localparam int MaxLevelsDef   = 8;
  localparam int PoolEntriesDef = 64;
  localparam int TaskIdBitsDef  = 16;
  localparam int ActiveRstDef   = 8;

  localparam int OpW    = 2;
  localparam int PrioW  = 4;
  localparam int CountW = 7;
  localparam int ErrW   = 2;
  localparam int OutIdW = 16;

  typedef enum logic [OpW-1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_QUERY = 2'd2,
    OP_SPARE = 2'd3
  } op_t;

  typedef enum logic [ErrW-1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2,
    ERR_PRIO  = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_OUT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;   // capture input word
    logic exec;   // apply operation
    logic rd;     // read head task from pool
    logic show;   // register result word
  } cmd_t;

  // Datapath to controller status: nothing beyond strobes today.
  typedef struct packed {
    logic busy_unused;
  } stat_t;

endpackage

/* src/spmq_ctrl.sv */
// Controller: sequences load, execute, head read and result hand-off.
module spmq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output spmq_pkg::cmd_t    cmd
);

  spmq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spmq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command strobes; a result in ST_OUT may be taken while
  // the next word is loaded.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      spmq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = spmq_pkg::ST_EXEC;
        end
      end
      spmq_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = spmq_pkg::ST_READ;
      end
      spmq_pkg::ST_READ: begin
        cmd.rd    = 1'b1;
        cmd.show  = 1'b1;
        state_nxt = spmq_pkg::ST_OUT;
      end
      spmq_pkg::ST_OUT: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            cmd.load  = 1'b1;
            state_nxt = spmq_pkg::ST_EXEC;
          end else begin
            state_nxt = spmq_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = spmq_pkg::ST_IDLE;
    endcase
  end

endmodule

/* src/spmq_dp.sv */
// Datapath: level tables, linked-list pool memory and result registers.
module spmq_dp #(
  parameter int MAX_LEVELS   = spmq_pkg::MaxLevelsDef,
  parameter int POOL_ENTRIES = spmq_pkg::PoolEntriesDef,
  parameter int TASK_ID_BITS = spmq_pkg::TaskIdBitsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  spmq_pkg::cmd_t               cmd,
  input  logic [spmq_pkg::PrioW-1:0]   active_levels,
  input  logic [spmq_pkg::OpW-1:0]     in_operation,
  input  logic [TASK_ID_BITS-1:0]      in_task_id,
  input  logic [spmq_pkg::PrioW-1:0]   in_priority_req,
  output logic [spmq_pkg::OutIdW-1:0]  out_next_task_id,
  output logic [spmq_pkg::PrioW-1:0]   out_next_priority,
  output logic [spmq_pkg::CountW-1:0]  out_total_count,
  output logic [spmq_pkg::CountW-1:0]  out_level_count,
  output logic [spmq_pkg::ErrW-1:0]    out_error_code
);

  localparam int AW = $clog2(POOL_ENTRIES);
  localparam int LW = $clog2(MAX_LEVELS);
  localparam int CW = $clog2(POOL_ENTRIES + 1);
  localparam int PW = $clog2(MAX_LEVELS + 1);

  // pool memories
  logic [TASK_ID_BITS-1:0] task_mem [POOL_ENTRIES];
  logic [AW-1:0]           link_mem [POOL_ENTRIES];

  // per-level tables
  logic [AW-1:0] head_r [MAX_LEVELS];
  logic [AW-1:0] tail_r [MAX_LEVELS];
  logic [CW-1:0] size_r [MAX_LEVELS];
  logic [CW-1:0] total_r;
  logic [AW-1:0] free_head_r;
  logic [CW-1:0] fill_r;

  // captured word
  logic [spmq_pkg::OpW-1:0]   op_r;
  logic [TASK_ID_BITS-1:0]    id_r;
  logic [spmq_pkg::PrioW-1:0] prio_r;

  // registered link read (next of current top head, or of the free head)
  logic [AW-1:0] link_rd_r;

  // result stage
  logic [spmq_pkg::ErrW-1:0]  err_r;
  logic [PW-1:0]              top_lvl_r;
  logic                       top_any_r;
  logic [AW-1:0]              top_head_r;
  logic [TASK_ID_BITS-1:0]    task_rd_r;
  logic [spmq_pkg::OutIdW-1:0]  res_id_r;
  logic [spmq_pkg::PrioW-1:0]   res_prio_r;
  logic [spmq_pkg::CountW-1:0]  res_tot_r;
  logic [spmq_pkg::CountW-1:0]  res_lvl_r;
  logic [spmq_pkg::ErrW-1:0]    res_err_r;

  // clamp active level count
  logic [PW-1:0] lim;
  always_comb begin
    if (active_levels == '0) begin
      lim = PW'(1);
    end else if (int'(active_levels) > MAX_LEVELS) begin
      lim = PW'(MAX_LEVELS);
    end else begin
      lim = PW'(active_levels);
    end
  end

  logic prio_ok;
  logic [LW-1:0] plv;
  assign prio_ok = (prio_r != '0) && (int'(prio_r) <= int'(lim));
  assign plv     = LW'(prio_r - 4'd1);

  // highest non-empty active level
  logic          any_c;
  logic [LW-1:0] top_c;
  always_comb begin
    any_c = 1'b0;
    top_c = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if ((PW'(i) < lim) && (size_r[i] != '0)) begin
        any_c = 1'b1;
        top_c = LW'(i);
      end
    end
  end

  logic          enq_go, deq_go;
  logic [AW-1:0] new_e;
  logic          use_free;
  assign enq_go   = (op_r == spmq_pkg::OP_ENQ) && prio_ok &&
                    (total_r < CW'(POOL_ENTRIES));
  assign deq_go   = (op_r == spmq_pkg::OP_DEQ) && any_c;
  assign use_free = fill_r > total_r;
  assign new_e    = use_free ? free_head_r : AW'(fill_r);

  // link read at load: next of the current top head; also the free list's
  // successor, since only one is needed per operation
  logic [AW-1:0] link_addr;
  assign link_addr = (in_operation == spmq_pkg::OP_ENQ) ? free_head_r : head_r[top_c];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      link_rd_r <= link_mem[link_addr];
      op_r      <= in_operation;
      id_r      <= in_task_id;
      prio_r    <= in_priority_req;
    end
    if (cmd.exec) begin
      if (enq_go) begin
        task_mem[new_e] <= id_r;
      end
    end
    if (cmd.exec && enq_go && size_r[plv] != '0) begin
      link_mem[tail_r[plv]] <= new_e;
    end else if (cmd.exec && deq_go) begin
      link_mem[head_r[top_c]] <= free_head_r;
    end
    if (cmd.rd) begin
      task_rd_r <= task_mem[top_head_r];
    end
  end

  // table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        size_r[i] <= '0;
      end
      total_r     <= '0;
      free_head_r <= '0;
      fill_r      <= '0;
    end else if (cmd.exec) begin
      if (enq_go) begin
        if (use_free) begin
          free_head_r <= link_rd_r;
        end else begin
          fill_r <= fill_r + CW'(1);
        end
        if (size_r[plv] == '0) begin
          head_r[plv] <= new_e;
        end
        tail_r[plv] <= new_e;
        size_r[plv] <= size_r[plv] + CW'(1);
        total_r     <= total_r + CW'(1);
      end else if (deq_go) begin
        head_r[top_c] <= link_rd_r;
        free_head_r   <= head_r[top_c];
        size_r[top_c] <= size_r[top_c] - CW'(1);
        total_r       <= total_r - CW'(1);
      end
    end
  end

  // error code of the operation
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      priority if (op_r == spmq_pkg::OP_ENQ) begin
        if (!prio_ok) begin
          err_r <= spmq_pkg::ERR_PRIO;
        end else if (total_r >= CW'(POOL_ENTRIES)) begin
          err_r <= spmq_pkg::ERR_FULL;
        end else begin
          err_r <= spmq_pkg::ERR_OK;
        end
      end else if (op_r == spmq_pkg::OP_DEQ && !any_c) begin
        err_r <= spmq_pkg::ERR_EMPTY;
      end else begin
        err_r <= prio_ok ? spmq_pkg::ERR_OK : spmq_pkg::ERR_PRIO;
      end
    end
  end

  // in the read cycle tables are updated; register top and counts
  always_ff @(posedge clk) begin
    if (cmd.show) begin
      top_any_r  <= any_c;
      top_lvl_r  <= PW'(top_c) + PW'(1);
      res_tot_r  <= spmq_pkg::CountW'(total_r);
      res_lvl_r  <= prio_ok ? spmq_pkg::CountW'(size_r[plv]) : '0;
      res_err_r  <= err_r;
    end
  end
  assign top_head_r = head_r[top_c];

  always_comb begin
    res_id_r   = top_any_r ? spmq_pkg::OutIdW'(task_rd_r) : '0;
    res_prio_r = top_any_r ? spmq_pkg::PrioW'(top_lvl_r) : '0;
  end

  assign out_next_task_id  = res_id_r;
  assign out_next_priority = res_prio_r;
  assign out_total_count   = res_tot_r;
  assign out_level_count   = res_lvl_r;
  assign out_error_code    = res_err_r;

endmodule

/* src/strict_priority_multi_queue.sv */
// Top level of the strict-priority multi-queue with its register port.
//  channel | direction | handshake          | words
//  in_     | input     | in_valid/in_ready  | operation, task id, priority
//  out_    | output    | out_valid/out_ready| head, level, counts, error
//  p       | input     | APB psel/penable   | active_levels at address 0
// From acceptance to result an operation runs in steps: load with the pool
// link read, table update, then pool task read for the new head.
// A waiting result stalls intake; the next word is loaded on the cycle the
// result is taken. Reset empties all levels at once; no clearing pass.
module strict_priority_multi_queue #(
  parameter int MAX_LEVELS   = spmq_pkg::MaxLevelsDef,
  parameter int POOL_ENTRIES = spmq_pkg::PoolEntriesDef,
  parameter int TASK_ID_BITS = spmq_pkg::TaskIdBitsDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [spmq_pkg::OpW-1:0]    in_operation,
  input  logic [TASK_ID_BITS-1:0]     in_task_id,
  input  logic [spmq_pkg::PrioW-1:0]  in_priority_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [spmq_pkg::OutIdW-1:0] out_next_task_id,
  output logic [spmq_pkg::PrioW-1:0]  out_next_priority,
  output logic [spmq_pkg::CountW-1:0] out_total_count,
  output logic [spmq_pkg::CountW-1:0] out_level_count,
  output logic [spmq_pkg::ErrW-1:0]   out_error_code,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [1:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  spmq_pkg::cmd_t cmd;
  logic [spmq_pkg::PrioW-1:0] active_r;

  // register port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= spmq_pkg::PrioW'(spmq_pkg::ActiveRstDef);
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      active_r <= pwdata[spmq_pkg::PrioW-1:0];
    end
  end
  assign prdata = (paddr == 2'd0) ? {28'd0, active_r} : 32'd0;

  spmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  spmq_dp #(
    .MAX_LEVELS   (MAX_LEVELS),
    .POOL_ENTRIES (POOL_ENTRIES),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .active_levels     (active_r),
    .in_operation      (in_operation),
    .in_task_id        (in_task_id),
    .in_priority_req   (in_priority_req),
    .out_next_task_id  (out_next_task_id),
    .out_next_priority (out_next_priority),
    .out_total_count   (out_total_count),
    .out_level_count   (out_level_count),
    .out_error_code    (out_error_code)
  );

endmodule
